/* sv/crc32de_pkg.sv */
// ----------------------------------------------------------------------------
// crc32de_pkg
// Shared types, constants and CRC step functions for the dual-mode CRC engine.
// ----------------------------------------------------------------------------
package crc32de_pkg;

	localparam logic [31:0] POLY_REFLECTED = 32'hEDB8_8320;
	localparam logic [31:0] POLY_NORMAL    = 32'h04C1_1DB7;
	localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

	// crc_mode codes
	localparam logic MODE_REFLECTED = 1'b0;
	localparam logic MODE_MPEG2     = 1'b1;

	// configuration register indexes
	localparam int  CFG_IDX_W       = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 1'b1;

	// byte slots of a partial mode-1 word
	localparam logic [1:0] SLOT_LAST = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic        fire;
		logic [31:0] crc_value;
	} result_t;

	// One reflected byte step (LSB first); unrolls into an XOR network.
	function automatic logic [31:0] absorb_byte_reflected(input logic [31:0] c_in,
	                                                      input logic [7:0]  b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ POLY_REFLECTED) : (c >> 1);
		end
		return c;
	endfunction

	// One MSB-first word step; linear in its inputs, so it is a flat XOR tree.
	function automatic logic [31:0] absorb_word_msb(input logic [31:0] c_in,
	                                                input logic [31:0] w);
		logic [31:0] c;
		c = c_in ^ w;
		for (int i = 0; i < 32; i++) begin
			c = c[31] ? ((c << 1) ^ POLY_NORMAL) : (c << 1);
		end
		return c;
	endfunction

endpackage

/* sv/crc32_dual_mode_engine.sv */
// ----------------------------------------------------------------------------
// crc32_dual_mode_engine
// Byte-stream CRC-32 engine, reflected CRC-32 or MPEG-2 word-wise CRC-32.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle, save while a last byte waits for room in
// the result register, and gives the final CRC on the request that carries
// tlast. tuser marks the first byte of a message, which reloads the CRC from
// start_value (inverted in reflected mode). crc_mode is sampled per byte: 0 is
// reflected CRC-32 (0xEDB88320, inverted in and out), 1 is the MPEG-2 form,
// where bytes pack little-endian into 32-bit words, a partial last word is
// zero-padded, and words shift MSB-first through 0x04C11DB7 with no inversion.
// A request passes the input register, then the CRC update into the result
// register. Throughput is one byte every cycle while no last byte is held;
// it is set by the CRC feedback loop, which absorbs one byte or one whole
// word per update. Write the configuration only while no request is in
// flight, neither a byte in the input register nor a pending message result.
// ----------------------------------------------------------------------------
module crc32_dual_mode_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [crc32de_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                       cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // [7:0] data_byte
	input  logic                              s_tuser,  // [0] first_byte
	input  logic                              s_tlast,  // last_byte
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata   // [31:0] crc_value
);
	import crc32de_pkg::*;

	// configuration registers
	logic        crc_mode_q;
	logic [31:0] start_value_q;

	// input stage
	logic  valid_s1;
	item_t item_s1;

	logic    out_free;
	logic    advance;
	result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_mode_q    <= MODE_REFLECTED;
			start_value_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CRC_MODE:    crc_mode_q    <= cfg_data[0];
				REG_START_VALUE: start_value_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// A byte that gives no result moves on at once; a last byte waits for
	// room in the result register.
	assign advance  = valid_s1 && (!item_s1.last_byte || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte  <= s_tdata;
			item_s1.first_byte <= s_tuser;
			item_s1.last_byte  <= s_tlast;
		end
	end

	crc32de_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.item        (item_s1),
		.crc_mode    (crc_mode_q),
		.start_value (start_value_q),
		.result      (result)
	);

	crc32de_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* sv/crc32de_core.sv */
// ----------------------------------------------------------------------------
// crc32de_core
// Running CRC state and its next-state logic; one byte per enabled cycle.
// ----------------------------------------------------------------------------
module crc32de_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  crc32de_pkg::item_t   item,
	input  logic                 crc_mode,
	input  logic [31:0]          start_value,
	output crc32de_pkg::result_t result
);
	import crc32de_pkg::*;

	logic [31:0] crc_q;
	logic [23:0] pend_q;
	logic [1:0]  slot_q;

	logic [31:0] crc_base, crc_n, word_in;
	logic [23:0] pend_base, pend_n;
	logic [1:0]  slot_base, slot_n;
	logic        do_word;

	always_comb begin
		crc_base  = item.first_byte ? ((crc_mode == MODE_MPEG2) ? start_value : ~start_value)
		                            : crc_q;
		pend_base = item.first_byte ? 24'd0 : pend_q;
		slot_base = item.first_byte ? 2'd0  : slot_q;

		pend_n  = pend_base;
		slot_n  = slot_base;
		word_in = 32'd0;
		do_word = 1'b0;

		if (crc_mode == MODE_MPEG2) begin
			if (slot_base == SLOT_LAST) begin
				// word complete: absorb it
				word_in = {item.data_byte, pend_base};
				do_word = 1'b1;
				pend_n  = 24'd0;
				slot_n  = 2'd0;
			end else begin
				case (slot_base)
					2'd0:    pend_n = {pend_base[23:8], item.data_byte};
					2'd1:    pend_n = {pend_base[23:16], item.data_byte, pend_base[7:0]};
					default: pend_n = {item.data_byte, pend_base[15:0]};
				endcase
				slot_n = slot_base + 2'd1;
				if (item.last_byte) begin
					// zero-padded partial word
					word_in = {8'd0, pend_n};
					do_word = 1'b1;
				end
			end
			if (item.last_byte) begin
				pend_n = 24'd0;
				slot_n = 2'd0;
			end
			crc_n = do_word ? absorb_word_msb(crc_base, word_in) : crc_base;
		end else begin
			crc_n = absorb_byte_reflected(crc_base, item.data_byte);
		end

		result.fire      = en & item.last_byte;
		result.crc_value = (crc_mode == MODE_MPEG2) ? crc_n : (crc_n ^ ALL_ONES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			pend_q <= '0;
			slot_q <= '0;
		end else if (en) begin
			crc_q  <= crc_n;
			pend_q <= pend_n;
			slot_q <= slot_n;
		end
	end

endmodule

/* sv/crc32de_out_reg.sv */
// ----------------------------------------------------------------------------
// crc32de_out_reg
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
module crc32de_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crc32de_pkg::result_t result,
	output logic                 free,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata
);
	import crc32de_pkg::*;

	logic        valid_q;
	logic [31:0] data_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= result.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (result.fire) begin
			data_q <= result.crc_value;
		end
	end

endmodule

/* tb/crc32_dual_mode_engine_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc32_dual_mode_engine_tb
// Self-checking bench for the dual-mode byte-stream CRC-32 engine.
// ----------------------------------------------------------------------------
// Drives bytes with first/last flags into the input stream. A local model
// tracks the running CRC in both modes. Each message CRC seen on the result
// stream is compared against the oldest predicted value. Directed messages
// come first: known vectors, single-byte messages, bytes with no start, and
// mode or start changes mid-message. Random messages follow, under three
// backpressure profiles, with register changes between blocks.
// ----------------------------------------------------------------------------
module crc32_dual_mode_engine_tb;
	import crc32de_pkg::*;

	localparam int QUIET_LIMIT = 4000;  // cycles with no request before giving up
	localparam int HOLD_CYCLES = 300;   // long result-side stall
	localparam int DRAIN_GAP   = 4;     // covers the input and result registers of the pipeline

	// ------------------------------------------------------------------------
	// Running CRC model plus the queue of message CRCs still due.
	// ------------------------------------------------------------------------
	class crc_checker;
		logic                 mode;
		logic [31:0]          seed;
		logic [31:0]          crc_acc;
		logic [23:0]          word_buf;   // partial MPEG-2 word, little-endian
		logic [1:0]           slot;       // bytes held in word_buf
		logic [31:0]          due_crcs[$];
		int                   errors;

		function new();
			mode     = MODE_REFLECTED;
			seed     = '0;
			crc_acc  = '0;
			word_buf = '0;
			slot     = '0;
			errors   = 0;
		endfunction

		// reflected byte fold: feedback is the low bit xor the next data bit
		function automatic logic [31:0] fold_lsb(logic [31:0] acc, logic [7:0] b);
			logic [31:0] r;
			logic        fb;
			r = acc;
			for (int k = 0; k < 8; k++) begin
				fb = r[0] ^ b[k];
				r  = {1'b0, r[31:1]} ^ (fb ? POLY_REFLECTED : 32'h0);
			end
			return r;
		endfunction

		// MSB-first word fold, no reflection
		function automatic logic [31:0] fold_msb(logic [31:0] acc, logic [31:0] w);
			logic [31:0] r;
			r = acc ^ w;
			for (int k = 0; k < 32; k++)
				r = {r[30:0], 1'b0} ^ (r[31] ? POLY_NORMAL : 32'h0);
			return r;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx == REG_CRC_MODE)
				mode = data[0];
			else if (idx == REG_START_VALUE)
				seed = data;
		endfunction

		function void note_byte(logic [7:0] b, logic first, logic last);
			if (first) begin
				crc_acc  = (mode == MODE_MPEG2) ? seed : ~seed;
				word_buf = '0;
				slot     = '0;
			end
			if (mode == MODE_REFLECTED) begin
				// word buffer is left alone in this mode
				crc_acc = fold_lsb(crc_acc, b);
				if (last)
					due_crcs.push_back(~crc_acc);
				return;
			end
			if (slot == SLOT_LAST) begin
				crc_acc  = fold_msb(crc_acc, {b, word_buf});
				word_buf = '0;
				slot     = '0;
			end else begin
				word_buf[8*slot +: 8] = b;
				slot = slot + 2'd1;
			end
			if (last) begin
				// zero-pad a partial word in its high bytes
				if (slot != 2'd0)
					crc_acc = fold_msb(crc_acc, {8'h00, word_buf});
				word_buf = '0;
				slot     = '0;
				due_crcs.push_back(crc_acc);
			end
		endfunction

		function void check_crc(logic [31:0] got);
			logic [31:0] want;
			if (due_crcs.size() == 0) begin
				$display("%0t: unexpected crc_value, expected none, actual %08h", $time, got);
				errors++;
				return;
			end
			want = due_crcs.pop_front();
			if (got !== want) begin
				$display("%0t: crc_value mismatch, expected %08h, actual %08h",
				         $time, want, got);
				errors++;
			end
		endfunction

		function int outstanding();
			return due_crcs.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals; the ones the bench drives are known from time zero
	// ------------------------------------------------------------------------
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;   // [7:0] data_byte
	logic                 s_tuser   = 1'b0; // [0] first_byte
	logic                 s_tlast   = 1'b0; // last_byte
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [31:0]          m_tdata;          // [31:0] crc_value

	crc_checker crc_chk = new();

	int tx_idle_pct = 0;   // chance per request that the sender waits first
	int rx_idle_pct = 0;   // chance per cycle that the receiver stalls
	bit hold_req    = 1'b0;
	int hold_left   = 0;

	crc32_dual_mode_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Result side: random stalls, plus a long hold-off when asked for.
	// The hold is counted here so the sender keeps pushing meanwhile.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		bit rdy;
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else begin
			rdy = ($urandom_range(99) >= rx_idle_pct);
		end
		m_tready <= rdy;
	end

	// Monitors sample at the edge, before any of this step's updates land.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			crc_chk.note_byte(s_tdata, s_tuser, s_tlast);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			crc_chk.check_crc(m_tdata);
	end

	// Watchdog: stop when neither side has moved a request for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("crc32_dual_mode_engine regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	// Offer one byte, returning right after the edge that takes it.
	task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering and wait for every due CRC, then let the pipe empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (crc_chk.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// Both registers, back to back; only called with the block drained.
	task automatic write_regs(input logic mode, input logic [31:0] seed);
		cfg_we    <= 1'b1;
		cfg_index <= REG_CRC_MODE;
		cfg_data  <= {31'd0, mode};
		@(posedge clk);
		crc_chk.set_register(REG_CRC_MODE, {31'd0, mode});
		cfg_index <= REG_START_VALUE;
		cfg_data  <= seed;
		@(posedge clk);
		crc_chk.set_register(REG_START_VALUE, seed);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly well-formed messages; some drop a flag or scramble them.
	task automatic send_message(output int sent);
		int len;
		int pick;
		int broken;
		logic [7:0] b;
		logic f;
		logic l;
		pick = $urandom_range(99);
		if (pick < 70)
			len = $urandom_range(8, 1);
		else if (pick < 95)
			len = $urandom_range(24, 9);
		else
			len = $urandom_range(80, 25);
		broken = ($urandom_range(99) < 12) ? $urandom_range(3, 1) : 0;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0)
				b = $urandom_range(1) ? 8'hFF : 8'h00;
			else
				b = 8'($urandom);
			f = (i == 0);
			l = (i == len - 1);
			case (broken)
				1: f = 1'b0;                 // continues from the running CRC
				2: l = 1'b0;                 // runs into the next message
				3: begin
					f = 1'($urandom_range(1));
					l = 1'($urandom_range(1));
				end
				default: ;
			endcase
			send_byte(b, f, l);
		end
		sent = len;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0] check_str[9];
		logic       mode;
		logic [31:0] seed;
		int         sent;
		int         block_count;

		check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reflected mode, seed 0 -> standard CRC-32 init of all ones.
		// A byte with no start right after reset runs from the reset CRC.
		send_byte(8'h00, 1'b0, 1'b0);
		drain();
		write_regs(MODE_REFLECTED, 32'h0000_0000);
		send_byte(8'hFF, 1'b1, 1'b1);            // single-byte message
		for (int i = 0; i < 9; i++)
			send_byte(check_str[i], i == 0, i == 8);
		send_byte(8'hA5, 1'b0, 1'b1);            // no start after a result

		// MPEG-2 mode: full word, single partial byte, word plus partial.
		drain();
		write_regs(MODE_MPEG2, 32'hFFFF_FFFF);
		send_byte(8'h12, 1'b1, 1'b0);
		send_byte(8'h34, 1'b0, 1'b0);
		send_byte(8'h56, 1'b0, 1'b0);
		send_byte(8'h78, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b1);
		for (int i = 1; i <= 5; i++)
			send_byte(8'(i), i == 1, i == 5);

		// Mode and seed flipped mid-message: a reflected byte in the middle
		// must leave the partial word alone; new seed waits for next start.
		drain();
		write_regs(MODE_MPEG2, 32'h0000_0000);
		send_byte(8'hAA, 1'b1, 1'b0);
		drain();
		write_regs(MODE_REFLECTED, 32'h1234_5678);
		send_byte(8'h55, 1'b0, 1'b0);
		drain();
		write_regs(MODE_MPEG2, 32'hFFFF_FFFF);
		send_byte(8'h0F, 1'b0, 1'b1);

		// Random part: three backpressure profiles, four register blocks each.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 27;
					rx_idle_pct = 86;
				end
				1: begin
					tx_idle_pct = 86;
					rx_idle_pct = 27;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				drain();
				mode = 1'($urandom_range(1));
				case ($urandom_range(3))
					0:       seed = 32'h0000_0000;
					1:       seed = 32'hFFFF_FFFF;
					default: seed = $urandom;
				endcase
				write_regs(mode, seed);
				// long result stall with the sender still pushing
				if (phase == 2 && blk == 0)
					hold_req = 1'b1;
				block_count = 0;
				while (block_count < 140) begin
					send_message(sent);
					block_count += sent;
					// sender pause until every due CRC is back
					if (blk == 1 && block_count >= 70 && block_count - sent < 70)
						drain();
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (crc_chk.errors == 0)
			$display("crc32_dual_mode_engine regression: pass");
		else
			$display("crc32_dual_mode_engine regression: fail");
		$finish;
	end

endmodule
